@@ rtl/sws_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the sliding-window sender.
package sws_pkg;

  localparam int CMD_BITS = 2;
  localparam logic [CMD_BITS-1:0] CMD_SUBMIT  = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_ACK     = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_TIMEOUT = 2'd2;

  localparam int ACT_BITS = 2;
  localparam logic [ACT_BITS-1:0] ACT_NONE   = 2'd0;
  localparam logic [ACT_BITS-1:0] ACT_SEND   = 2'd1;
  localparam logic [ACT_BITS-1:0] ACT_RESEND = 2'd2;
  localparam logic [ACT_BITS-1:0] ACT_IGNORE = 2'd3;

  localparam int TMR_BITS = 2;
  localparam logic [TMR_BITS-1:0] TMR_NONE  = 2'd0;

  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 16;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MARKER       = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LIMIT = 8'd1;

  localparam int MAGIC_BITS = 16;
  localparam int LIMIT_BITS = 5;
  localparam logic [MAGIC_BITS-1:0] MAGIC_RESET = 16'd729;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd10;

  // ACK bytes, byte 0 in the lowest bits
  typedef struct packed {
    logic [7:0]            b6;
    logic [7:0]            seq;
    logic [7:0]            b4;
    logic [7:0]            b3;
    logic [7:0]            b2;
    logic [MAGIC_BITS-1:0] marker;
  } ack_frame_t;

  localparam int ACK_BITS = $bits(ack_frame_t);

  typedef struct packed {
    logic [ACT_BITS-1:0] action;
    logic                overflow;
    logic [TMR_BITS-1:0] timer_cmd;
    logic                last;
  } res_ctl_t;

endpackage

@@ rtl/sliding_window_sender_top.sv @@
`timescale 1ns / 1ps
// Top level of the cumulative-ACK sliding-window sender.
//
//   channel  signals                                  role
//   s_*      s_tvalid s_tready s_tdata s_tuser        events in (submit, ACK, timeout)
//   m_*      m_tvalid m_tready m_tdata m_tuser m_tlast result beats out
//   cfg_*    cfg_valid cfg_ready cfg_index cfg_data   register writes
//
// Overflow, ignored ACK, timeout and reserved events pass EXEC then OUT; a submit or
// an accepted ACK passes EXEC, FILL and OUT whether or not it sends; each further
// packet released by the same event runs FILL and OUT again, FILL issuing the
// registered read of the handle ring. One event is worked at a time; the next is
// taken once its last beat is in the output register. A stalled m_tready holds the
// sequencer. Register writes are taken only while idle with no event offered. The
// ring needs no clearing after reset; rst clears counters, timer flag and registers.
module sliding_window_sender_top #(
  parameter int WINDOW_MAX  = 16,
  parameter int RING_DEPTH  = 1024,
  parameter int SEQ_BITS    = 7,
  parameter int HANDLE_BITS = 16,
  localparam int IN_BITS  = HANDLE_BITS + sws_pkg::ACK_BITS,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = HANDLE_BITS + SEQ_BITS + 1 + sws_pkg::TMR_BITS,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // packet_handle, ack_marker, ack_copy_b2, ack_copy_b3, ack_copy_b4,
  // ack_seq_byte, ack_copy_b6, zero pad
  input  logic [IN_W-1:0]                       s_tdata,
  // cmd
  input  logic [sws_pkg::CMD_BITS-1:0]          s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // send_handle, send_seq, overflow, timer_cmd, zero pad
  output logic [OUT_W-1:0]                      m_tdata,
  // action
  output logic [sws_pkg::ACT_BITS-1:0]          m_tuser,
  output logic                                  m_tlast,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [sws_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [sws_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  localparam int AW      = $clog2(RING_DEPTH);
  localparam int OVF_POS = HANDLE_BITS + SEQ_BITS;
  localparam int TMR_LO  = OVF_POS + 1;

  logic [sws_pkg::MAGIC_BITS-1:0] marker_ref;
  logic [sws_pkg::LIMIT_BITS-1:0] window_limit;

  sws_pkg::ack_frame_t   in_ack;
  logic                  ring_wr_en;
  logic [AW-1:0]         ring_wr_addr;
  logic [HANDLE_BITS-1:0] ring_wr_data;
  logic                  ring_rd_en;
  logic [AW-1:0]         ring_rd_addr;
  logic [HANDLE_BITS-1:0] ring_rd_data;
  logic                  res_valid;
  logic                  res_ready;
  sws_pkg::res_ctl_t     res_ctl;
  logic [HANDLE_BITS-1:0] res_handle;
  logic [SEQ_BITS-1:0]   res_seq;

  assign in_ack    = sws_pkg::ack_frame_t'(s_tdata[HANDLE_BITS +: sws_pkg::ACK_BITS]);
  assign cfg_ready = s_tready && !s_tvalid;
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      marker_ref   <= sws_pkg::MAGIC_RESET;
      window_limit <= sws_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sws_pkg::REG_MARKER:       marker_ref   <= cfg_data;
        sws_pkg::REG_WINDOW_LIMIT: window_limit <= cfg_data[sws_pkg::LIMIT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  sws_ring #(.DEPTH(RING_DEPTH), .WIDTH(HANDLE_BITS)) u_ring (
    .clk     (clk),
    .wr_en   (ring_wr_en),
    .wr_addr (ring_wr_addr),
    .wr_data (ring_wr_data),
    .rd_en   (ring_rd_en),
    .rd_addr (ring_rd_addr),
    .rd_data (ring_rd_data)
  );

  sws_ctrl #(
    .WINDOW_MAX  (WINDOW_MAX),
    .RING_DEPTH  (RING_DEPTH),
    .SEQ_BITS    (SEQ_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (s_tvalid),
    .item_ready   (s_tready),
    .item_cmd     (s_tuser),
    .item_handle  (s_tdata[HANDLE_BITS-1:0]),
    .item_ack     (in_ack),
    .marker_ref   (marker_ref),
    .window_limit (window_limit),
    .ring_wr_en   (ring_wr_en),
    .ring_wr_addr (ring_wr_addr),
    .ring_wr_data (ring_wr_data),
    .ring_rd_en   (ring_rd_en),
    .ring_rd_addr (ring_rd_addr),
    .ring_rd_data (ring_rd_data),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res_ctl      (res_ctl),
    .res_handle   (res_handle),
    .res_seq      (res_seq)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= OUT_W'({res_ctl.timer_cmd, res_ctl.overflow, res_seq, res_handle});
      m_tuser <= res_ctl.action;
      m_tlast <= res_ctl.last;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[OVF_POS] |-> m_tlast && (m_tuser == sws_pkg::ACT_NONE))
    else $error("overflow beat not a lone idle result");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[TMR_LO +: sws_pkg::TMR_BITS] == sws_pkg::TMR_NONE)
    else $error("timer command on a non-final beat");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == sws_pkg::ACT_IGNORE) |->
      m_tlast && (m_tdata[HANDLE_BITS-1:0] == '0))
    else $error("ignored ACK beat carries a handle or is not final");

  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready && !res_valid)
    else $error("event accepted while the sequencer was busy");
`endif

endmodule

@@ rtl/sws_ring.sv @@
`timescale 1ns / 1ps
// Handle ring: one write port, one registered read port.
module sws_ring #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/sws_ack_chk.sv @@
`timescale 1ns / 1ps
// ACK validation and offset of the acked sequence from the oldest in flight.
module sws_ack_chk #(
  parameter int SEQ_BITS = 7
) (
  input  sws_pkg::ack_frame_t             ack,
  input  logic [sws_pkg::MAGIC_BITS-1:0]  magic,
  input  logic [SEQ_BITS-1:0]             oldest,
  output logic                            hit,
  output logic [SEQ_BITS-1:0]             dpos
);

  assign hit = (ack.marker == magic) && (ack.b2 == ack.b3) && (ack.b3 == ack.b4) &&
               (ack.b4 == ack.seq) && (ack.seq == ack.b6);

  assign dpos = SEQ_BITS'(ack.seq) - oldest;

endmodule

@@ rtl/sws_ctrl.sv @@
`timescale 1ns / 1ps
// Window sequencer: counters, timer flag and the writes and reads of the ring.
module sws_ctrl #(
  parameter int WINDOW_MAX  = 16,
  parameter int RING_DEPTH  = 1024,
  parameter int SEQ_BITS    = 7,
  parameter int HANDLE_BITS = 16,
  localparam int AW = $clog2(RING_DEPTH)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  logic [sws_pkg::CMD_BITS-1:0]        item_cmd,
  input  logic [HANDLE_BITS-1:0]              item_handle,
  input  sws_pkg::ack_frame_t                 item_ack,
  input  logic [sws_pkg::MAGIC_BITS-1:0]      marker_ref,
  input  logic [sws_pkg::LIMIT_BITS-1:0]      window_limit,
  output logic                                ring_wr_en,
  output logic [AW-1:0]                       ring_wr_addr,
  output logic [HANDLE_BITS-1:0]              ring_wr_data,
  output logic                                ring_rd_en,
  output logic [AW-1:0]                       ring_rd_addr,
  input  logic [HANDLE_BITS-1:0]              ring_rd_data,
  output logic                                res_valid,
  input  logic                                res_ready,
  output sws_pkg::res_ctl_t                   res_ctl,
  output logic [HANDLE_BITS-1:0]              res_handle,
  output logic [SEQ_BITS-1:0]                 res_seq
);

  localparam int WW  = $clog2(RING_DEPTH + 1);
  localparam int IFW = $clog2(WINDOW_MAX + 1);
  localparam logic [AW:0] DEPTH_W = (AW+1)'(RING_DEPTH);
  localparam logic [SEQ_BITS-1:0] SEQ_MASK = '1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_FILL = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]                       state;
  logic [sws_pkg::CMD_BITS-1:0]     cmd_q;
  logic [HANDLE_BITS-1:0]           handle_q;
  sws_pkg::ack_frame_t              ack_q;
  logic [AW-1:0]                    head;
  logic [IFW-1:0]                   inflight;
  logic [WW-1:0]                    waiting;
  logic [SEQ_BITS-1:0]              oldest;
  logic                             timer_running;
  logic                             stop_q;
  logic                             start_q;
  logic                             out_mem;
  logic [sws_pkg::ACT_BITS-1:0]     res_act_q;
  logic                             res_ovf_q;
  logic                             res_last_q;
  logic [SEQ_BITS-1:0]              res_seq_q;

  logic [IFW-1:0]                   lim;
  logic                             ack_hit;
  logic [SEQ_BITS-1:0]              dpos;
  logic                             ack_take;
  logic                             full;
  logic                             fill_go;
  logic                             fill_last;

  function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
    wrap = (s >= DEPTH_W) ? AW'(s - DEPTH_W) : AW'(s);
  endfunction

  sws_ack_chk #(.SEQ_BITS(SEQ_BITS)) u_ack_chk (
    .ack    (ack_q),
    .magic  (marker_ref),
    .oldest (oldest),
    .hit    (ack_hit),
    .dpos   (dpos)
  );

  always_comb begin
    if (window_limit == '0) begin
      lim = IFW'(1);
    end else if (int'(window_limit) > WINDOW_MAX) begin
      lim = IFW'(WINDOW_MAX);
    end else begin
      lim = IFW'(window_limit);
    end
  end

  assign ack_take  = ack_hit && (inflight != '0) && (int'(dpos) < int'(inflight));
  assign full      = ({1'b0, waiting} + (WW+1)'(inflight)) >= (WW+1)'(RING_DEPTH);
  assign fill_go   = (waiting != '0) && (inflight < lim);
  assign fill_last = (waiting == WW'(1)) || ((inflight + IFW'(1)) >= lim);

  assign item_ready = (state == ST_IDLE);

  assign ring_wr_en   = (state == ST_EXEC) && (cmd_q == sws_pkg::CMD_SUBMIT) && !full;
  assign ring_wr_addr = wrap({1'b0, head} + (AW+1)'(inflight) + (AW+1)'(waiting));
  assign ring_wr_data = handle_q;
  assign ring_rd_en   = ((state == ST_FILL) && fill_go) ||
                        ((state == ST_EXEC) && (cmd_q == sws_pkg::CMD_TIMEOUT) &&
                         (inflight != '0));
  assign ring_rd_addr = (state == ST_FILL) ? wrap({1'b0, head} + (AW+1)'(inflight)) : head;

  assign res_valid         = (state == ST_OUT);
  assign res_ctl.action    = res_act_q;
  assign res_ctl.overflow  = res_ovf_q;
  assign res_ctl.timer_cmd = res_last_q ? {stop_q, start_q} : sws_pkg::TMR_NONE;
  assign res_ctl.last      = res_last_q;
  assign res_handle        = out_mem ? ring_rd_data : '0;
  assign res_seq           = res_seq_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      head          <= '0;
      inflight      <= '0;
      waiting       <= '0;
      oldest        <= '0;
      timer_running <= 1'b0;
      stop_q        <= 1'b0;
      start_q       <= 1'b0;
      out_mem       <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            state   <= ST_EXEC;
            stop_q  <= 1'b0;
            start_q <= 1'b0;
          end
        end
        ST_EXEC: begin
          out_mem <= 1'b0;
          state   <= ST_OUT;
          case (cmd_q)
            sws_pkg::CMD_SUBMIT: begin
              if (!full) begin
                waiting <= waiting + WW'(1);
                state   <= ST_FILL;
              end
            end
            sws_pkg::CMD_ACK: begin
              if (ack_take) begin
                if (dpos != SEQ_MASK) begin
                  stop_q        <= 1'b1;
                  timer_running <= 1'b0;
                end
                head     <= wrap({1'b0, head} + (AW+1)'(dpos) + (AW+1)'(1));
                oldest   <= oldest + dpos + SEQ_BITS'(1);
                inflight <= inflight - IFW'(dpos) - IFW'(1);
                state    <= ST_FILL;
              end
            end
            sws_pkg::CMD_TIMEOUT: begin
              if (inflight != '0) begin
                timer_running <= 1'b1;
                start_q       <= 1'b1;
                out_mem       <= 1'b1;
              end else begin
                timer_running <= 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
        ST_FILL: begin
          state <= ST_OUT;
          if (fill_go) begin
            inflight <= inflight + IFW'(1);
            waiting  <= waiting - WW'(1);
            out_mem  <= 1'b1;
            if (!timer_running) begin
              timer_running <= 1'b1;
              start_q       <= 1'b1;
            end
          end else begin
            out_mem <= 1'b0;
            if ((inflight != '0) && !timer_running) begin
              timer_running <= 1'b1;
              start_q       <= 1'b1;
            end
          end
        end
        ST_OUT: begin
          if (res_ready) begin
            state <= res_last_q ? ST_IDLE : ST_FILL;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && item_valid) begin
      cmd_q    <= item_cmd;
      handle_q <= item_handle;
      ack_q    <= item_ack;
    end
    if (state == ST_EXEC) begin
      res_act_q  <= sws_pkg::ACT_NONE;
      res_ovf_q  <= 1'b0;
      res_last_q <= 1'b1;
      res_seq_q  <= '0;
      case (cmd_q)
        sws_pkg::CMD_SUBMIT: begin
          res_ovf_q <= full;
        end
        sws_pkg::CMD_ACK: begin
          if (!ack_take) begin
            res_act_q <= sws_pkg::ACT_IGNORE;
          end
        end
        sws_pkg::CMD_TIMEOUT: begin
          if (inflight != '0) begin
            res_act_q <= sws_pkg::ACT_RESEND;
            res_seq_q <= oldest;
          end
        end
        default: begin
        end
      endcase
    end
    if (state == ST_FILL) begin
      res_ovf_q <= 1'b0;
      if (fill_go) begin
        res_act_q  <= sws_pkg::ACT_SEND;
        res_last_q <= fill_last;
        res_seq_q  <= oldest + SEQ_BITS'(inflight);
      end else begin
        res_act_q  <= sws_pkg::ACT_NONE;
        res_last_q <= 1'b1;
        res_seq_q  <= '0;
      end
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for sliding_window_sender_top: event stream in, send beats out.
module testbench;
  import sws_pkg::*;

  localparam int RING = 1024;
  localparam int WIN_MAX = 16;
  localparam int HOLD_CYCLES = 400;
  localparam logic [CMD_BITS-1:0] CMD_RESERVED = 2'd3;

  typedef struct {
    logic [ACT_BITS-1:0] action;
    logic [15:0]         handle;
    logic [6:0]          sq;
    logic                overflow;
    logic [TMR_BITS-1:0] timer;
    logic                last;
  } beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [71:0] s_tdata = '0;
  logic [CMD_BITS-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [ACT_BITS-1:0] m_tuser;
  logic m_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // sender window state as seen from outside
  logic [15:0] handle_ring [RING];
  logic [9:0] ring_head = '0;
  int unsigned in_flight = 0;
  int unsigned waiting = 0;
  logic [6:0] oldest = '0;
  bit timer_on = 1'b0;
  logic [MAGIC_BITS-1:0] magic = MAGIC_RESET;
  logic [LIMIT_BITS-1:0] wlimit = LIMIT_RESET;

  beat_t step_q[$];
  beat_t send_plan[$];
  int unsigned errors = 0;
  int unsigned idle_pct = 29;
  bit hold_req = 1'b0;

  sliding_window_sender_top DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAIL sliding_window_sender_top");
    $finish;
  end

  task automatic flag(input string what, input int unsigned got, input int unsigned want);
    errors++;
    if (errors <= 40) $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
  endtask

  function automatic int unsigned eff_window();
    if (wlimit == 0) return 1;
    if (wlimit > WIN_MAX) return WIN_MAX;
    return wlimit;
  endfunction

  function automatic void add_beat(input logic [ACT_BITS-1:0] act, input logic [15:0] h,
                                   input logic [6:0] sq, input logic ovf);
    beat_t b;
    b.action = act;
    b.handle = h;
    b.sq = sq;
    b.overflow = ovf;
    b.timer = TMR_NONE;
    b.last = 1'b0;
    step_q.push_back(b);
  endfunction

  // move waiting handles into the window; 1 if the timer had to start
  function automatic bit promote();
    bit started = 1'b0;
    while (waiting > 0 && in_flight < eff_window()) begin
      add_beat(ACT_SEND, handle_ring[(int'(ring_head) + in_flight) % RING],
               7'(oldest + in_flight), 1'b0);
      in_flight++;
      waiting--;
      if (!timer_on) begin
        timer_on = 1'b1;
        started = 1'b1;
      end
    end
    return started;
  endfunction

  function automatic void window_step(input logic [CMD_BITS-1:0] cmd, input logic [15:0] h,
                                      input ack_frame_t f);
    logic [6:0] dpos;
    bit ok;
    bit stop = 1'b0;
    bit start = 1'b0;
    bit refill = 1'b0;
    case (cmd)
      CMD_SUBMIT: begin
        if (in_flight + waiting >= RING) begin
          add_beat(ACT_NONE, '0, '0, 1'b1);
        end else begin
          handle_ring[(int'(ring_head) + in_flight + waiting) % RING] = h;
          waiting++;
          start = promote();
          refill = 1'b1;
        end
      end
      CMD_ACK: begin
        ok = f.marker == magic && f.b2 == f.b3 && f.b3 == f.b4 && f.b4 == f.seq &&
             f.seq == f.b6;
        dpos = 7'(f.seq[6:0] - oldest);
        if (!ok || in_flight == 0 || dpos >= in_flight) begin
          add_beat(ACT_IGNORE, '0, '0, 1'b0);
        end else begin
          stop = 1'b1;
          timer_on = 1'b0;
          ring_head = 10'((int'(ring_head) + dpos + 1) % RING);
          oldest = 7'(oldest + dpos + 1);
          in_flight -= dpos + 1;
          start = promote();
          refill = 1'b1;
        end
      end
      CMD_TIMEOUT: begin
        timer_on = 1'b0;
        if (in_flight != 0) begin
          add_beat(ACT_RESEND, handle_ring[ring_head], oldest, 1'b0);
          timer_on = 1'b1;
          start = 1'b1;
        end else begin
          add_beat(ACT_NONE, '0, '0, 1'b0);
        end
      end
      default: begin
        add_beat(ACT_NONE, '0, '0, 1'b0);
      end
    endcase
    if (refill) begin
      if (in_flight != 0 && !timer_on) begin
        timer_on = 1'b1;
        start = 1'b1;
      end
      if (step_q.size() == 0) add_beat(ACT_NONE, '0, '0, 1'b0);
    end
    step_q[step_q.size()-1].timer = {stop, start};
    step_q[step_q.size()-1].last = 1'b1;
    foreach (step_q[i]) send_plan.push_back(step_q[i]);
    step_q.delete();
  endfunction

  // result beats: m_tdata = send_handle, send_seq, overflow, timer_cmd
  always @(posedge clk) begin : beat_check
    beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (send_plan.size() == 0) begin
        flag("unexpected beat", m_tuser, 0);
      end else begin
        want = send_plan.pop_front();
        if (m_tuser !== want.action) flag("action", m_tuser, want.action);
        if (m_tdata[15:0] !== want.handle) flag("send_handle", m_tdata[15:0], want.handle);
        if (m_tdata[22:16] !== want.sq) flag("send_seq", m_tdata[22:16], want.sq);
        if (m_tdata[23] !== want.overflow) flag("overflow", m_tdata[23], want.overflow);
        if (m_tdata[25:24] !== want.timer) flag("timer_cmd", m_tdata[25:24], want.timer);
        if (m_tlast !== want.last) flag("last", m_tlast, want.last);
      end
    end
  end

  initial begin : sink
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= idle_pct == 0 || $urandom_range(99, 0) >= idle_pct;
      end
    end
  end

  task automatic send_event(input logic [CMD_BITS-1:0] cmd, input logic [15:0] h,
                            input ack_frame_t f);
    while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {f, h};
    do @(posedge clk); while (!s_tready);
    window_step(cmd, h, f);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (send_plan.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_MARKER) magic = val;
    else if (idx == REG_WINDOW_LIMIT) wlimit = val[LIMIT_BITS-1:0];
    @(posedge clk);
  endtask

  function automatic ack_frame_t noise_frame();
    ack_frame_t f;
    f.marker = 16'($urandom_range(65535, 0));
    f.b2 = 8'($urandom_range(255, 0));
    f.b3 = 8'($urandom_range(255, 0));
    f.b4 = 8'($urandom_range(255, 0));
    f.seq = 8'($urandom_range(255, 0));
    f.b6 = 8'($urandom_range(255, 0));
    return f;
  endfunction

  function automatic ack_frame_t ack_frame(input logic [7:0] sq);
    ack_frame_t f;
    f.marker = magic;
    f.b2 = sq;
    f.b3 = sq;
    f.b4 = sq;
    f.seq = sq;
    f.b6 = sq;
    return f;
  endfunction

  task automatic submit(input logic [15:0] h);
    send_event(CMD_SUBMIT, h, noise_frame());
  endtask

  task automatic ack(input ack_frame_t f);
    send_event(CMD_ACK, 16'($urandom_range(65535, 0)), f);
  endtask

  task automatic ack_seq(input logic [7:0] sq);
    ack(ack_frame(sq));
  endtask

  task automatic expire_timer();
    send_event(CMD_TIMEOUT, 16'($urandom_range(65535, 0)), noise_frame());
  endtask

  task automatic ack_in_window();
    int unsigned dpos;
    dpos = $urandom_range(in_flight - 1, 0);
    ack_seq({1'($urandom_range(1, 0)), 7'(oldest + dpos)});
  endtask

  task automatic ack_outside();
    int unsigned r;
    r = $urandom_range(127 - in_flight, 0);
    ack_seq({1'($urandom_range(1, 0)), 7'(oldest + in_flight + r)});
  endtask

  task automatic ack_corrupt();
    ack_frame_t f;
    logic [7:0] flip;
    f = ack_frame(8'($urandom_range(255, 0)));
    flip = 8'($urandom_range(255, 1));
    case ($urandom_range(6, 0))
      0: f.marker ^= {flip, 8'($urandom_range(255, 0))};
      1: f.b2 ^= flip;
      2: f.b3 ^= flip;
      3: f.b4 ^= flip;
      4: f.seq ^= flip;
      5: f.b6 ^= flip;
      default: f = noise_frame();
    endcase
    ack(f);
  endtask

  task automatic flush_window();
    while (in_flight + waiting != 0) ack_seq({1'b0, 7'(oldest + in_flight - 1)});
  endtask

  task automatic random_event();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < ((in_flight + waiting > 40) ? 25 : 45)) begin
      submit(16'($urandom_range(65535, 0)));
    end else if (r < 75) begin
      if (in_flight != 0) ack_in_window();
      else expire_timer();
    end else if (r < 83) begin
      ack_corrupt();
    end else if (r < 88) begin
      ack_outside();
    end else if (r < 98) begin
      expire_timer();
    end else begin
      send_event(CMD_RESERVED, 16'($urandom_range(65535, 0)), noise_frame());
    end
  endtask

  // reset registers: window 10, default marker
  task automatic test_directed();
    ack_frame_t f;
    submit(16'h0000);
    submit(16'hFFFF);
    repeat (10) submit(16'($urandom_range(65535, 0)));
    expire_timer();
    ack_seq({1'b0, 7'(oldest - 1)});
    f = ack_frame({1'b0, 7'(oldest + 2)});
    f.marker = ~magic;
    ack(f);
    for (int i = 0; i < 5; i++) begin
      f = ack_frame({1'b0, 7'(oldest + 2)});
      case (i)
        0: f.b2 ^= 8'hFF;
        1: f.b3 ^= 8'h01;
        2: f.b4 ^= 8'h80;
        3: f.seq ^= 8'h80;
        default: f.b6 ^= 8'h10;
      endcase
      ack(f);
    end
    ack_seq({1'b1, 7'(oldest + 3)});
    ack_seq({1'b0, 7'(oldest + in_flight)});
    send_event(CMD_RESERVED, 16'hFFFF, noise_frame());
    ack_seq({1'b0, 7'(oldest + in_flight - 1)});
    expire_timer();
    ack_seq(8'h00);
  endtask

  task automatic test_register_extremes();
    write_reg(REG_MARKER, 16'hFFFF);
    write_reg(REG_WINDOW_LIMIT, 16'd0);
    repeat (3) submit(16'($urandom_range(65535, 0)));
    ack_seq({1'b0, oldest});
    write_reg(REG_MARKER, 16'h0000);
    ack_seq({1'b1, oldest});
    write_reg(REG_WINDOW_LIMIT, 16'd31);
    repeat (20) submit(16'($urandom_range(65535, 0)));
    write_reg(REG_WINDOW_LIMIT, 16'd16);
    repeat (2) submit(16'($urandom_range(65535, 0)));
    // shrink below the in-flight count: nothing freed, promotion held back
    write_reg(REG_WINDOW_LIMIT, 16'd3);
    ack_seq({1'b0, oldest});
    expire_timer();
    ack_seq({1'b0, 7'(oldest + in_flight - 1)});
    flush_window();
    write_reg(REG_WINDOW_LIMIT, 16'd16);
  endtask

  task automatic test_backpressure();
    write_reg(REG_WINDOW_LIMIT, 16'd4);
    hold_req = 1'b1;
    repeat (40) random_event();
  endtask

  task automatic test_no_idle();
    idle_pct = 0;
    repeat (60) random_event();
    idle_pct = 29;
  endtask

  task automatic test_random_phases();
    logic [CFG_DATA_BITS-1:0] lim;
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_MARKER, p == 0 ? MAGIC_RESET : 16'($urandom_range(65535, 0)));
      case (p)
        0: lim = 16'd10;
        1: lim = 16'd1;
        2: lim = 16'd16;
        default: lim = 16'($urandom_range(31, 0));
      endcase
      write_reg(REG_WINDOW_LIMIT, lim);
      repeat (40) random_event();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_register_extremes();
    test_backpressure();
    test_no_idle();
    test_random_phases();
    settle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS sliding_window_sender_top");
    end else begin
      $display("FAIL sliding_window_sender_top");
    end
    $finish;
  end

endmodule
